>>> sv/nested_scope_cycle_profiler_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nested scope cycle profiler
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef NESTED_SCOPE_CYCLE_PROFILER_UNIT_ASSERT_SVH
`define NESTED_SCOPE_CYCLE_PROFILER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define NSCP_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define NSCP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/nscp_pkg.sv
// ----------------------------------------------------------------------------
// nscp_pkg
// Types, sizes and codes shared by the scope profiler modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nscp_pkg;

    localparam int NUM_SLOTS   = 128;
    localparam int STACK_DEPTH = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam int SLOT_W  = $clog2(NUM_SLOTS);
    localparam int FRAME_W = $clog2(STACK_DEPTH);
    localparam int LEVEL_W = $clog2(STACK_DEPTH + 1);
    localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int DATA_W  = 64;
    localparam int BYTES_W = 32;
    localparam int CMD_W   = 3;
    localparam int RAWS_W  = 7;
    localparam int STAT_W  = 2;

    typedef logic [SLOT_W-1:0]  t_slot;
    typedef logic [FRAME_W-1:0] t_frame_idx;
    typedef logic [LEVEL_W-1:0] t_level;
    typedef logic [QPTR_W-1:0]  t_qptr;
    typedef logic [QCNT_W-1:0]  t_qcnt;
    typedef logic [DATA_W-1:0]  t_word;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENTER = 3'd0,
        CMD_EXIT  = 3'd1,
        CMD_ADD   = 3'd2,
        CMD_READ  = 3'd3,
        CMD_CLEAR = 3'd4
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ENTER,
        OP_EXIT,
        OP_ADD,
        OP_READ,
        OP_CLEAR
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PREAD,
        ST_PEXEC
    } t_state;

    // One classified command as it travels from front to back.
    typedef struct packed {
        t_kind                kind;
        t_status              status;
        t_slot                slot;
        t_word                ts;
        logic [BYTES_W-1:0]   bytes;
        t_frame_idx           frame;
        logic                 has_parent;
    } t_op;

    typedef struct packed {
        t_word calls;
        t_word excl;
        t_word incl;
        t_word bytes;
    } t_row;

    // A frame keeps the slot of the frame below it, so a pop restores the top slot.
    typedef struct packed {
        t_slot parent;
        t_word start;
        t_word saved;
    } t_frame;

    localparam int ROW_W = $bits(t_row);
    localparam int FRM_W = $bits(t_frame);

endpackage

>>> sv/nested_scope_cycle_profiler_unit.sv
// ----------------------------------------------------------------------------
// nested_scope_cycle_profiler_unit
// Scope profiler: per-slot call, exclusive, inclusive and byte counters
// driven by a stack of open scopes.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; every command gives
// exactly one result, in command order, shown for one cycle with o_valid high.
// Results cannot be held off, so sample them on the strobe. Enter, add_bytes,
// read, clear and rejected commands take the executor through a registered
// read of the slot table, then the write back. An exit whose scope has an
// open parent adds a second read and write of the table for the parent row.
// The result strobe is registered from the final step, and the executor takes
// a further command from the queue only once it is done with the current one.
// Up to two commands wait in the intake queue; busy rises whenever both
// entries are taken, which happens as soon as commands arrive faster than
// the executor finishes them, and sooner behind an exit with a parent.
// Clear takes effect at once through per-slot valid flags and needs no sweep
// of the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nested_scope_cycle_profiler_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [nscp_pkg::CMD_W-1:0]         i_command,
    input  logic [nscp_pkg::RAWS_W-1:0]        i_slot,
    input  logic [nscp_pkg::DATA_W-1:0]        i_timestamp,
    input  logic [nscp_pkg::BYTES_W-1:0]       i_byte_count,
    output logic                               o_valid,
    output logic [nscp_pkg::STAT_W-1:0]        o_status,
    output logic [nscp_pkg::DATA_W-1:0]        o_call_count,
    output logic [nscp_pkg::DATA_W-1:0]        o_exclusive_cycles,
    output logic [nscp_pkg::DATA_W-1:0]        o_inclusive_cycles,
    output logic [nscp_pkg::DATA_W-1:0]        o_byte_total
);

    // Classified command crossing from intake to execution.
    logic          push;
    nscp_pkg::t_op push_op;
    logic          pop;
    nscp_pkg::t_op head_op;
    logic          q_empty;
    logic          q_full;

    // Intake: decide status and frame position now, from its own depth count,
    // so the executor never has to look at the stack level.
    nscp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_full       (q_full),
        .i_command    (i_command),
        .i_slot       (i_slot),
        .i_timestamp  (i_timestamp),
        .i_byte_count (i_byte_count),
        .o_push       (push),
        .o_op         (push_op)
    );

    // Hold commands while the executor works through a long exit.
    nscp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .i_pop   (pop),
        .o_head  (head_op),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // Execution: read-modify-write of slot rows, push and pop of frames,
    // and the registered result transfer.
    nscp_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_head             (head_op),
        .i_empty            (q_empty),
        .o_pop              (pop),
        .o_valid            (o_valid),
        .o_status           (o_status),
        .o_call_count       (o_call_count),
        .o_exclusive_cycles (o_exclusive_cycles),
        .o_inclusive_cycles (o_inclusive_cycles),
        .o_byte_total       (o_byte_total)
    );

    // Stall intake only when no queue entry is free.
    assign busy = q_full;

endmodule

>>> sv/nscp_ram.sv
// ----------------------------------------------------------------------------
// nscp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nscp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/nscp_front.sv
// ----------------------------------------------------------------------------
// nscp_front
// Command intake: tracks stack depth, resolves status and frame index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nscp_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    input  logic                               i_full,
    input  logic [nscp_pkg::CMD_W-1:0]         i_command,
    input  logic [nscp_pkg::RAWS_W-1:0]        i_slot,
    input  logic [nscp_pkg::DATA_W-1:0]        i_timestamp,
    input  logic [nscp_pkg::BYTES_W-1:0]       i_byte_count,
    output logic                               o_push,
    output nscp_pkg::t_op                      o_op
);

    nscp_pkg::t_level r_level;
    nscp_pkg::t_level n_level;
    logic             accept;

    assign accept = start && !i_full;

    always_comb begin
        n_level         = r_level;
        o_op.kind       = nscp_pkg::OP_NONE;
        o_op.status     = nscp_pkg::STAT_OK;
        o_op.slot       = i_slot[nscp_pkg::SLOT_W-1:0];
        o_op.ts         = i_timestamp;
        o_op.bytes      = i_byte_count;
        o_op.frame      = r_level[nscp_pkg::FRAME_W-1:0];
        o_op.has_parent = 1'b0;
        unique case (nscp_pkg::t_cmd'(i_command))
            nscp_pkg::CMD_ENTER: begin
                if (r_level == nscp_pkg::t_level'(nscp_pkg::STACK_DEPTH)) begin
                    o_op.status = nscp_pkg::STAT_FULL;
                end else begin
                    o_op.kind = nscp_pkg::OP_ENTER;
                    n_level   = r_level + 1'b1;
                end
            end
            nscp_pkg::CMD_EXIT: begin
                if (r_level == '0) begin
                    o_op.status = nscp_pkg::STAT_EMPTY;
                end else begin
                    o_op.kind       = nscp_pkg::OP_EXIT;
                    o_op.frame      = nscp_pkg::t_frame_idx'(r_level - 1'b1);
                    o_op.has_parent = (r_level > nscp_pkg::t_level'(1));
                    n_level         = r_level - 1'b1;
                end
            end
            nscp_pkg::CMD_ADD: begin
                if (r_level == '0) begin
                    o_op.status = nscp_pkg::STAT_EMPTY;
                end else begin
                    o_op.kind = nscp_pkg::OP_ADD;
                end
            end
            nscp_pkg::CMD_READ: begin
                o_op.kind = nscp_pkg::OP_READ;
            end
            nscp_pkg::CMD_CLEAR: begin
                o_op.kind = nscp_pkg::OP_CLEAR;
            end
            default: begin
                o_op.kind = nscp_pkg::OP_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (accept) begin
            r_level <= n_level;
        end
    end

    assign o_push = accept;

endmodule

>>> sv/nscp_queue.sv
// ----------------------------------------------------------------------------
// nscp_queue
// Short FIFO of classified commands between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "nested_scope_cycle_profiler_unit_assert.svh"

module nscp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  nscp_pkg::t_op i_op,
    input  logic          i_pop,
    output nscp_pkg::t_op o_head,
    output logic          o_empty,
    output logic          o_full
);

    nscp_pkg::t_op   r_mem [nscp_pkg::QUEUE_DEPTH];
    nscp_pkg::t_qptr r_wr;
    nscp_pkg::t_qptr r_rd;
    nscp_pkg::t_qcnt r_count;

    function automatic nscp_pkg::t_qptr ptr_next(input nscp_pkg::t_qptr p);
        ptr_next = (p == nscp_pkg::t_qptr'(nscp_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_next(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_next(r_rd);
            end
            priority if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == nscp_pkg::t_qcnt'(nscp_pkg::QUEUE_DEPTH));

    `NSCP_ASSERT(a_no_push_full, i_push, !o_full, "transfer pushed into a full queue")
    `NSCP_ASSERT(a_no_pop_empty, i_pop, !o_empty, "pop from an empty queue")

endmodule

>>> sv/nscp_back.sv
// ----------------------------------------------------------------------------
// nscp_back
// Executes classified commands on the slot table and the frame stack.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "nested_scope_cycle_profiler_unit_assert.svh"

module nscp_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  nscp_pkg::t_op                 i_head,
    input  logic                          i_empty,
    output logic                          o_pop,
    output logic                          o_valid,
    output logic [nscp_pkg::STAT_W-1:0]   o_status,
    output logic [nscp_pkg::DATA_W-1:0]   o_call_count,
    output logic [nscp_pkg::DATA_W-1:0]   o_exclusive_cycles,
    output logic [nscp_pkg::DATA_W-1:0]   o_inclusive_cycles,
    output logic [nscp_pkg::DATA_W-1:0]   o_byte_total
);

    nscp_pkg::t_state r_state;
    nscp_pkg::t_state n_state;
    nscp_pkg::t_op    r_op;
    nscp_pkg::t_slot  r_addr;
    nscp_pkg::t_slot  r_top_slot;
    nscp_pkg::t_slot  n_top_slot;
    nscp_pkg::t_slot  r_parent;
    nscp_pkg::t_word  r_spent;
    logic [nscp_pkg::NUM_SLOTS-1:0] r_row_vld;
    logic             r_vld_q;

    logic             r_valid;
    nscp_pkg::t_status r_status;
    nscp_pkg::t_row   r_result;

    logic                          tbl_we;
    logic                          tbl_re;
    nscp_pkg::t_slot               tbl_waddr;
    nscp_pkg::t_slot               tbl_raddr;
    logic [nscp_pkg::ROW_W-1:0]    tbl_rdata;
    logic                          stk_we;
    logic                          stk_re;
    logic [nscp_pkg::FRM_W-1:0]    stk_rdata;
    nscp_pkg::t_row                row_cur;
    nscp_pkg::t_row                row_new;
    nscp_pkg::t_row                rd_row;
    nscp_pkg::t_frame              frame_cur;
    nscp_pkg::t_frame              frame_new;
    nscp_pkg::t_word               spent;
    logic                          clear_all;
    logic                          done;

    nscp_ram #(
        .WIDTH (nscp_pkg::ROW_W),
        .DEPTH (nscp_pkg::NUM_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (row_new),
        .i_re    (tbl_re),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    nscp_ram #(
        .WIDTH (nscp_pkg::FRM_W),
        .DEPTH (nscp_pkg::STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (r_op.frame),
        .i_wdata (frame_new),
        .i_re    (stk_re),
        .i_raddr (i_head.frame),
        .o_rdata (stk_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nscp_pkg::ST_IDLE: begin
                if (!i_empty) begin
                    n_state = nscp_pkg::ST_EXEC;
                end
            end
            nscp_pkg::ST_EXEC: begin
                if (r_op.kind == nscp_pkg::OP_EXIT && r_op.has_parent) begin
                    n_state = nscp_pkg::ST_PREAD;
                end else begin
                    n_state = nscp_pkg::ST_IDLE;
                end
            end
            nscp_pkg::ST_PREAD: n_state = nscp_pkg::ST_PEXEC;
            nscp_pkg::ST_PEXEC: n_state = nscp_pkg::ST_IDLE;
            default:            n_state = nscp_pkg::ST_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        o_pop     = (r_state == nscp_pkg::ST_IDLE) && !i_empty;
        stk_re    = o_pop;
        tbl_re    = o_pop || (r_state == nscp_pkg::ST_PREAD);
        if (r_state == nscp_pkg::ST_PREAD) begin
            tbl_raddr = r_parent;
        end else if (i_head.kind == nscp_pkg::OP_ENTER || i_head.kind == nscp_pkg::OP_READ) begin
            tbl_raddr = i_head.slot;
        end else begin
            tbl_raddr = r_top_slot;
        end

        row_cur   = r_vld_q ? nscp_pkg::t_row'(tbl_rdata) : '0;
        frame_cur = nscp_pkg::t_frame'(stk_rdata);
        spent     = r_op.ts - frame_cur.start;

        tbl_we     = 1'b0;
        tbl_waddr  = r_addr;
        row_new    = row_cur;
        stk_we     = 1'b0;
        frame_new  = '{parent: r_top_slot, start: r_op.ts, saved: row_cur.incl};
        clear_all  = 1'b0;
        done       = 1'b0;
        rd_row     = '0;
        n_top_slot = r_top_slot;

        unique case (r_state)
            nscp_pkg::ST_EXEC: begin
                unique case (r_op.kind)
                    nscp_pkg::OP_ENTER: begin
                        row_new.bytes = row_cur.bytes + nscp_pkg::t_word'(r_op.bytes);
                        tbl_we        = 1'b1;
                        stk_we        = 1'b1;
                        n_top_slot    = r_op.slot;
                        done          = 1'b1;
                    end
                    nscp_pkg::OP_EXIT: begin
                        row_new.excl  = row_cur.excl + spent;
                        row_new.incl  = frame_cur.saved + spent;
                        row_new.calls = row_cur.calls + 1'b1;
                        tbl_we        = 1'b1;
                        n_top_slot    = frame_cur.parent;
                        done          = !r_op.has_parent;
                    end
                    nscp_pkg::OP_ADD: begin
                        row_new.bytes = row_cur.bytes + nscp_pkg::t_word'(r_op.bytes);
                        tbl_we        = 1'b1;
                        done          = 1'b1;
                    end
                    nscp_pkg::OP_READ: begin
                        rd_row = row_cur;
                        done   = 1'b1;
                    end
                    nscp_pkg::OP_CLEAR: begin
                        clear_all = 1'b1;
                        done      = 1'b1;
                    end
                    default: begin
                        done = 1'b1;
                    end
                endcase
            end
            nscp_pkg::ST_PEXEC: begin
                tbl_waddr    = r_parent;
                row_new.excl = row_cur.excl - r_spent;
                tbl_we       = 1'b1;
                done         = 1'b1;
            end
            default: begin
                done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= nscp_pkg::ST_IDLE;
            r_top_slot <= '0;
            r_row_vld  <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_top_slot <= n_top_slot;
            r_valid    <= done;
            if (clear_all) begin
                r_row_vld <= '0;
            end else if (tbl_we) begin
                r_row_vld[tbl_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op <= i_head;
        end
        if (tbl_re) begin
            r_addr  <= tbl_raddr;
            r_vld_q <= r_row_vld[tbl_raddr];
        end
        if (r_state == nscp_pkg::ST_EXEC) begin
            r_parent <= frame_cur.parent;
            r_spent  <= spent;
        end
        if (done) begin
            r_status <= r_op.status;
            r_result <= rd_row;
        end
    end

    assign o_valid            = r_valid;
    assign o_status           = r_status;
    assign o_call_count       = r_result.calls;
    assign o_exclusive_cycles = r_result.excl;
    assign o_inclusive_cycles = r_result.incl;
    assign o_byte_total       = r_result.bytes;

    `NSCP_ASSERT_NEXT(a_strobe_gap, r_valid, !r_valid, "result strobe held for two cycles")
    `NSCP_ASSERT(a_err_zero, r_valid && r_status != nscp_pkg::STAT_OK, r_result == '0, "error result carries counters")

endmodule
